// ===== hw/rtl/halftone_dot_pixel_renderer_assert.svh =====
// Assertion macros for the halftone dot renderer checkers.
`ifndef HALFTONE_DOT_PIXEL_RENDERER_ASSERT_SVH
`define HALFTONE_DOT_PIXEL_RENDERER_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define HDPR_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent assertion on clk and rst_n of the enclosing scope.
`define HDPR_ASSERT(lbl, prop, msg) \
  `HDPR_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ===== hw/rtl/hdpr_pkg.sv =====
package hdpr_pkg;

  localparam int LEVEL_BITS    = 5;
  localparam int MAX_HALF_SIZE = 16;

  localparam int CFG_W       = 5;
  localparam int HALF_RESET  = 8;
  localparam int LUMA_W      = 8;
  localparam int OFS_W       = 5;
  localparam int PIX_W       = 24;
  localparam int EXT_W       = 7;

  localparam int LUMA_BLACK       = 16;
  localparam int LUMA_WHITE       = 235;
  localparam int LUMA_RECIP_SHIFT = 24;
  localparam int LUMA_RECIP       = 71393;
  localparam int LUMA_SCALE       = 255 * LUMA_RECIP;
  localparam int LUMA_SCALE_W     = $clog2(LUMA_SCALE + 1);
  localparam int LUMA_PROD_W      = LUMA_W + LUMA_SCALE_W;

  localparam int HS_W   = $clog2(MAX_HALF_SIZE + 1);
  localparam int DIST_W = ($clog2(MAX_HALF_SIZE) > 0) ? $clog2(MAX_HALF_SIZE) : 1;
  localparam int SUB_N  = 4;
  localparam int SUB_W  = DIST_W + 2;
  localparam int SQ_W   = 2 * SUB_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int NSUB   = SUB_N * SUB_N;
  localparam int CNT_W  = $clog2(NSUB + 1);
  localparam int CNT_MAX = 15;

  localparam int DENOM    = 1 << LEVEL_BITS;
  localparam int GROW_MAX = DENOM + 4 * (DENOM - 1);
  localparam int GROW_W   = $clog2(GROW_MAX + 1);
  localparam int G_SQ_W   = 2 * GROW_W;
  localparam int H_SQ_W   = 2 * HS_W;
  localparam int RHS_SH   = 4;
  localparam int RHS_W    = RHS_SH + H_SQ_W + G_SQ_W;
  localparam int LHS_SCALE = 25 * DENOM * DENOM;
  localparam int LHS_W    = SUM_W + $clog2(LHS_SCALE + 1);
  localparam int CMP_W    = (RHS_W > LHS_W) ? RHS_W : LHS_W;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } front_ctl_t;

  typedef struct packed {
    logic ld3;
    logic ld4;
    logic ld5;
  } disk_ctl_t;

  typedef struct packed {
    logic                              blank;
    logic [LEVEL_BITS-1:0]             level;
    logic [H_SQ_W-1:0]                 h_sq;
    logic [SUB_N-1:0][SQ_W-1:0]        sq_y;
    logic [SUB_N-1:0][SQ_W-1:0]        sq_x;
  } prep_t;

endpackage

// ===== hw/rtl/halftone_dot_pixel_renderer.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    in_cell_luma, in_offset_x, in_offset_y
// out       output     out_valid/out_stall  out_pixel_rgb
// cfg       input      cfg_valid/cfg_ready  cfg_half_size
//
// Six register stages: luma scale and cell fold, level and squares, radius and
// subsample sums, radius product and subsample scaling, compare, count.
// One transaction per cycle is taken while out_stall is low.
// Reset (rst_n low, synchronous) empties the pipe and sets half_size to 8.
// A stall holds the full stages; empty stages keep filling, so in_stall rises
// only once every stage holds a transaction.
module halftone_dot_pixel_renderer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hdpr_pkg::LUMA_W-1:0]   in_cell_luma,
  input  logic [hdpr_pkg::OFS_W-1:0]    in_offset_x,
  input  logic [hdpr_pkg::OFS_W-1:0]    in_offset_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hdpr_pkg::PIX_W-1:0]    out_pixel_rgb,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hdpr_pkg::CFG_W-1:0]    cfg_half_size
);

  logic [hdpr_pkg::CFG_W-1:0] half_size_r;
  logic [5:1]                 vld_r;
  logic [6:1]                 ld;
  logic                       out_valid_r;
  hdpr_pkg::front_ctl_t       front_ctl;
  hdpr_pkg::disk_ctl_t        disk_ctl;
  hdpr_pkg::prep_t            prep;
  logic [hdpr_pkg::NSUB-1:0]  hit;
  logic [hdpr_pkg::CNT_W-1:0] cnt;
  logic [3:0]                 level_cnt;
  logic [hdpr_pkg::PIX_W-1:0] pixel_nxt, pixel_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_size_r <= hdpr_pkg::CFG_W'(hdpr_pkg::HALF_RESET);
    end else if (cfg_valid && cfg_ready) begin
      half_size_r <= cfg_half_size;
    end
  end

  // advance a stage when it is empty or the next stage advances
  always_comb begin
    ld[6] = !out_valid_r || !out_stall;
    for (int i = 5; i >= 1; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  assign in_stall = !ld[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int i = 2; i <= 5; i++) begin
        if (ld[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
      if (ld[6]) begin
        out_valid_r <= vld_r[5];
      end
    end
  end

  assign front_ctl.ld1 = ld[1];
  assign front_ctl.ld2 = ld[2];
  assign disk_ctl.ld3  = ld[3];
  assign disk_ctl.ld4  = ld[4];
  assign disk_ctl.ld5  = ld[5];

  hdpr_front u_front (
    .clk       (clk),
    .ctl       (front_ctl),
    .half_size (half_size_r),
    .cell_luma (in_cell_luma),
    .offset_x  (in_offset_x),
    .offset_y  (in_offset_y),
    .prep      (prep)
  );

  hdpr_disk u_disk (
    .clk  (clk),
    .ctl  (disk_ctl),
    .prep (prep),
    .hit  (hit)
  );

  always_comb begin
    cnt = '0;
    for (int k = 0; k < hdpr_pkg::NSUB; k++) begin
      cnt = cnt + hdpr_pkg::CNT_W'(hit[k]);
    end
    level_cnt = (cnt > hdpr_pkg::CNT_W'(hdpr_pkg::CNT_MAX)) ?
                4'(hdpr_pkg::CNT_MAX) : cnt[3:0];
    pixel_nxt = {level_cnt, 4'h0, level_cnt, 4'h0, level_cnt, 4'h0};
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_rgb = pixel_r;

endmodule

// ===== hw/rtl/hdpr_front.sv =====
module hdpr_front (
  input  logic                         clk,
  input  hdpr_pkg::front_ctl_t         ctl,
  input  logic [hdpr_pkg::CFG_W-1:0]   half_size,
  input  logic [hdpr_pkg::LUMA_W-1:0]  cell_luma,
  input  logic [hdpr_pkg::OFS_W-1:0]   offset_x,
  input  logic [hdpr_pkg::OFS_W-1:0]   offset_y,
  output hdpr_pkg::prep_t              prep
);

  logic [hdpr_pkg::EXT_W-1:0]       h_ext, rim_ext, ctr_ext, ox_ext, oy_ext, dx_ext, dy_ext;
  logic [hdpr_pkg::LUMA_W-1:0]      luma_off;
  logic [hdpr_pkg::LUMA_PROD_W-1:0] prod_nxt, prod_r;
  logic                             lo_nxt, hi_nxt, blank_nxt;
  logic                             lo_r, hi_r, blank_r;
  logic [hdpr_pkg::HS_W-1:0]        h_r;
  logic [hdpr_pkg::DIST_W-1:0]      dx_r, dy_r;

  logic [hdpr_pkg::LUMA_W-1:0]      mapped;
  hdpr_pkg::prep_t                  prep_nxt, prep_r;
  logic [hdpr_pkg::SUB_N-1:0][hdpr_pkg::SUB_W-1:0] sy, sx;

  always_comb begin
    h_ext = (hdpr_pkg::EXT_W'(half_size) > hdpr_pkg::EXT_W'(hdpr_pkg::MAX_HALF_SIZE)) ?
            hdpr_pkg::EXT_W'(hdpr_pkg::MAX_HALF_SIZE) : hdpr_pkg::EXT_W'(half_size);
    rim_ext = (h_ext << 1) - hdpr_pkg::EXT_W'(1);
    ctr_ext = h_ext - hdpr_pkg::EXT_W'(1);
    ox_ext  = hdpr_pkg::EXT_W'(offset_x);
    oy_ext  = hdpr_pkg::EXT_W'(offset_y);
    dx_ext  = (ox_ext >= ctr_ext) ? (ox_ext - ctr_ext) : (ctr_ext - ox_ext);
    dy_ext  = (oy_ext >= ctr_ext) ? (oy_ext - ctr_ext) : (ctr_ext - oy_ext);
    blank_nxt = (h_ext == '0) || (ox_ext >= rim_ext) || (oy_ext >= rim_ext);
    lo_nxt   = cell_luma < hdpr_pkg::LUMA_W'(hdpr_pkg::LUMA_BLACK);
    hi_nxt   = cell_luma > hdpr_pkg::LUMA_W'(hdpr_pkg::LUMA_WHITE);
    luma_off = cell_luma - hdpr_pkg::LUMA_W'(hdpr_pkg::LUMA_BLACK);
    prod_nxt = hdpr_pkg::LUMA_PROD_W'(luma_off) *
               hdpr_pkg::LUMA_PROD_W'(hdpr_pkg::LUMA_SCALE);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      prod_r  <= prod_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      blank_r <= blank_nxt;
      h_r     <= h_ext[hdpr_pkg::HS_W-1:0];
      dx_r    <= dx_ext[hdpr_pkg::DIST_W-1:0];
      dy_r    <= dy_ext[hdpr_pkg::DIST_W-1:0];
    end
  end

  always_comb begin
    if (lo_r) begin
      mapped = '0;
    end else if (hi_r) begin
      mapped = '1;
    end else begin
      mapped = prod_r[hdpr_pkg::LUMA_RECIP_SHIFT +: hdpr_pkg::LUMA_W];
    end
    prep_nxt.blank = blank_r;
    prep_nxt.level = mapped[hdpr_pkg::LUMA_W-1 -: hdpr_pkg::LEVEL_BITS];
    prep_nxt.h_sq  = hdpr_pkg::H_SQ_W'(h_r) * hdpr_pkg::H_SQ_W'(h_r);
    for (int u = 0; u < hdpr_pkg::SUB_N; u++) begin
      sy[u] = {dy_r, 2'(u)};
      sx[u] = {dx_r, 2'(u)};
      prep_nxt.sq_y[u] = hdpr_pkg::SQ_W'(sy[u]) * hdpr_pkg::SQ_W'(sy[u]);
      prep_nxt.sq_x[u] = hdpr_pkg::SQ_W'(sx[u]) * hdpr_pkg::SQ_W'(sx[u]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      prep_r <= prep_nxt;
    end
  end

  assign prep = prep_r;

endmodule

// ===== hw/rtl/hdpr_disk.sv =====
module hdpr_disk (
  input  logic                        clk,
  input  hdpr_pkg::disk_ctl_t         ctl,
  input  hdpr_pkg::prep_t             prep,
  output logic [hdpr_pkg::NSUB-1:0]   hit
);

  logic [hdpr_pkg::GROW_W-1:0]                      grow;
  logic [hdpr_pkg::G_SQ_W-1:0]                      g_sq_nxt, g_sq_r;
  logic [hdpr_pkg::H_SQ_W-1:0]                      h_sq_r;
  logic [hdpr_pkg::NSUB-1:0][hdpr_pkg::SUM_W-1:0]   sum_nxt, sum_r;
  logic                                             blank3_r, blank4_r;

  logic [hdpr_pkg::CMP_W-1:0]                       rhs_nxt, rhs_r;
  logic [hdpr_pkg::NSUB-1:0][hdpr_pkg::CMP_W-1:0]   lhs_nxt, lhs_r;
  logic [hdpr_pkg::NSUB-1:0]                        hit_nxt, hit_r;

  always_comb begin
    grow = hdpr_pkg::GROW_W'(hdpr_pkg::DENOM) + (hdpr_pkg::GROW_W'(prep.level) << 2);
    g_sq_nxt = hdpr_pkg::G_SQ_W'(grow) * hdpr_pkg::G_SQ_W'(grow);
    for (int u = 0; u < hdpr_pkg::SUB_N; u++) begin
      for (int v = 0; v < hdpr_pkg::SUB_N; v++) begin
        sum_nxt[u * hdpr_pkg::SUB_N + v] = hdpr_pkg::SUM_W'(prep.sq_y[u]) +
                                           hdpr_pkg::SUM_W'(prep.sq_x[v]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      g_sq_r   <= g_sq_nxt;
      h_sq_r   <= prep.h_sq;
      sum_r    <= sum_nxt;
      blank3_r <= prep.blank;
    end
  end

  always_comb begin
    rhs_nxt = (hdpr_pkg::CMP_W'(h_sq_r) * hdpr_pkg::CMP_W'(g_sq_r)) << hdpr_pkg::RHS_SH;
    for (int k = 0; k < hdpr_pkg::NSUB; k++) begin
      lhs_nxt[k] = hdpr_pkg::CMP_W'(sum_r[k]) * hdpr_pkg::CMP_W'(hdpr_pkg::LHS_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      rhs_r    <= rhs_nxt;
      lhs_r    <= lhs_nxt;
      blank4_r <= blank3_r;
    end
  end

  always_comb begin
    for (int k = 0; k < hdpr_pkg::NSUB; k++) begin
      hit_nxt[k] = !blank4_r && (lhs_r[k] < rhs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

// ===== hw/rtl/hdpr_checker.sv =====
`include "halftone_dot_pixel_renderer_assert.svh"

module hdpr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [hdpr_pkg::PIX_W-1:0]    out_pixel_rgb,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  logic out_held;
  logic grey_ok;

  assign out_held = out_valid && out_stall;
  assign grey_ok  = (out_pixel_rgb[23:16] == out_pixel_rgb[15:8]) &&
                    (out_pixel_rgb[15:8] == out_pixel_rgb[7:0]) &&
                    (out_pixel_rgb[3:0] == 4'h0);

  `HDPR_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_pixel_rgb), "held result changed")
  `HDPR_ASSERT(a_grey, out_valid |-> grey_ok, "result is not a grey multiple of 16")
  `HDPR_ASSERT(a_stall_cause, in_stall |-> out_held, "input stalled with room in the pipe")
  `HDPR_ASSERT(a_cfg_open, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind halftone_dot_pixel_renderer hdpr_checker u_hdpr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pixel_rgb (out_pixel_rgb),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int TB_LIMIT     = 400000;
  localparam int LATENCY_WAIT = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 125;

  typedef struct {
    logic [hdpr_pkg::PIX_W-1:0]  rgb;
    logic [hdpr_pkg::LUMA_W-1:0] luma;
    logic [hdpr_pkg::OFS_W-1:0]  ofs_x;
    logic [hdpr_pkg::OFS_W-1:0]  ofs_y;
    logic [hdpr_pkg::CFG_W-1:0]  half;
  } dot_pixel_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [hdpr_pkg::LUMA_W-1:0]   in_cell_luma;
  logic [hdpr_pkg::OFS_W-1:0]    in_offset_x;
  logic [hdpr_pkg::OFS_W-1:0]    in_offset_y;
  logic                          out_valid;
  logic                          out_stall;
  logic [hdpr_pkg::PIX_W-1:0]    out_pixel_rgb;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [hdpr_pkg::CFG_W-1:0]    cfg_half_size;

  logic                          sink_wait = 1'b0;
  logic                          hold_on = 1'b0;
  event                          hold_go;

  dot_pixel_t                    pending_pix_q[$];
  logic [hdpr_pkg::CFG_W-1:0]    half_cur;
  int                            src_gap_max = 19;
  int                            snk_gap_max = 19;
  int                            n_errors = 0;
  int unsigned                   n_cycles = 0;

  assign out_stall = sink_wait | hold_on;

  halftone_dot_pixel_renderer i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cell_luma  (in_cell_luma),
    .in_offset_x   (in_offset_x),
    .in_offset_y   (in_offset_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_rgb (out_pixel_rgb),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_half_size (cfg_half_size)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [hdpr_pkg::PIX_W-1:0] dot_pixel_rgb(
    input logic [hdpr_pkg::LUMA_W-1:0] luma,
    input logic [hdpr_pkg::OFS_W-1:0]  ofs_x,
    input logic [hdpr_pkg::OFS_W-1:0]  ofs_y,
    input logic [hdpr_pkg::CFG_W-1:0]  half
  );
    int      h;
    int      x;
    int      y;
    int      lum;
    int      mapped;
    int      lvl;
    int      d;
    int      dx;
    int      dy;
    int      cnt;
    longint  grow;
    longint  rhs;
    longint  sy;
    longint  sx;
    logic [3:0] c4;
    h   = (int'(half) > hdpr_pkg::MAX_HALF_SIZE) ? hdpr_pkg::MAX_HALF_SIZE : int'(half);
    x   = int'(ofs_x);
    y   = int'(ofs_y);
    lum = int'(luma);
    if (h == 0 || x >= 2 * h - 1 || y >= 2 * h - 1) begin
      return '0;
    end
    if (lum < 16) begin
      mapped = 0;
    end else if (lum > 235) begin
      mapped = 255;
    end else begin
      mapped = ((lum - 16) * 255) / 235;
    end
    lvl  = mapped >> (8 - hdpr_pkg::LEVEL_BITS);
    d    = 1 << hdpr_pkg::LEVEL_BITS;
    dx   = (x >= h - 1) ? x - (h - 1) : (h - 1) - x;
    dy   = (y >= h - 1) ? y - (h - 1) : (h - 1) - y;
    grow = d + 4 * lvl;
    rhs  = 64'd16 * h * h * grow * grow;
    cnt  = 0;
    for (int u = 0; u < 4; u++) begin
      for (int v = 0; v < 4; v++) begin
        sy = 4 * dy + u;
        sx = 4 * dx + v;
        if (64'd25 * d * d * (sy * sy + sx * sx) < rhs) cnt++;
      end
    end
    if (cnt > 15) cnt = 15;
    c4 = cnt[3:0];
    return {c4, 4'h0, c4, 4'h0, c4, 4'h0};
  endfunction

  task automatic send_pixel(input logic [hdpr_pkg::LUMA_W-1:0] luma,
                            input logic [hdpr_pkg::OFS_W-1:0]  ofs_x,
                            input logic [hdpr_pkg::OFS_W-1:0]  ofs_y);
    int         gap;
    dot_pixel_t pix;
    gap = $urandom_range(src_gap_max, 0);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_cell_luma <= luma;
    in_offset_x  <= ofs_x;
    in_offset_y  <= ofs_y;
    do @(posedge clk); while (in_stall);
    pix.rgb   = dot_pixel_rgb(luma, ofs_x, ofs_y, half_cur);
    pix.luma  = luma;
    pix.ofs_x = ofs_x;
    pix.ofs_y = ofs_y;
    pix.half  = half_cur;
    pending_pix_q.push_back(pix);
  endtask

  task automatic send_random_pixel();
    int h;
    logic [hdpr_pkg::OFS_W-1:0] ox;
    logic [hdpr_pkg::OFS_W-1:0] oy;
    h = (int'(half_cur) > hdpr_pkg::MAX_HALF_SIZE) ? hdpr_pkg::MAX_HALF_SIZE : int'(half_cur);
    if (h != 0 && $urandom_range(3, 0) != 0) begin
      ox = hdpr_pkg::OFS_W'($urandom_range(2 * h - 1, 0));
      oy = hdpr_pkg::OFS_W'($urandom_range(2 * h - 1, 0));
    end else begin
      ox = hdpr_pkg::OFS_W'($urandom_range(31, 0));
      oy = hdpr_pkg::OFS_W'($urandom_range(31, 0));
    end
    send_pixel(hdpr_pkg::LUMA_W'($urandom_range(255, 0)), ox, oy);
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pix_q.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_half_size(input logic [hdpr_pkg::CFG_W-1:0] half);
    drain_pipe();
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_half_size <= half;
    do @(posedge clk); while (!cfg_ready);
    half_cur = half;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_cell();
    send_pixel(8'd0,   5'd7,  5'd7);
    send_pixel(8'd15,  5'd7,  5'd7);
    send_pixel(8'd16,  5'd7,  5'd7);
    send_pixel(8'd235, 5'd7,  5'd7);
    send_pixel(8'd236, 5'd7,  5'd7);
    send_pixel(8'd255, 5'd7,  5'd7);
    send_pixel(8'd128, 5'd0,  5'd0);
    send_pixel(8'd255, 5'd14, 5'd14);
    send_pixel(8'd255, 5'd15, 5'd3);
    send_pixel(8'd255, 5'd3,  5'd15);
    send_pixel(8'd200, 5'd16, 5'd0);
    send_pixel(8'd255, 5'd31, 5'd31);
  endtask

  task automatic test_half_size_extremes();
    write_half_size(5'd1);
    send_pixel(8'd255, 5'd0,  5'd0);
    send_pixel(8'd255, 5'd1,  5'd0);
    send_pixel(8'd0,   5'd0,  5'd0);
    write_half_size(5'd16);
    send_pixel(8'd255, 5'd15, 5'd15);
    send_pixel(8'd255, 5'd0,  5'd30);
    send_pixel(8'd255, 5'd31, 5'd0);
    write_half_size(5'd31);
    send_pixel(8'd255, 5'd15, 5'd15);
    send_pixel(8'd128, 5'd30, 5'd30);
    send_pixel(8'd255, 5'd31, 5'd31);
    write_half_size(5'd0);
    send_pixel(8'd255, 5'd0,  5'd0);
    send_pixel(8'd128, 5'd5,  5'd5);
  endtask

  task automatic test_full_backpressure();
    write_half_size(5'd12);
    src_gap_max = 0;
    snk_gap_max = 0;
    @(negedge clk);
    -> hold_go;
    repeat (40) send_random_pixel();
  endtask

  task automatic test_random_cells();
    logic [hdpr_pkg::CFG_W-1:0] half;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       half = 5'd16;
        1:       half = 5'd1;
        2:       half = 5'd31;
        3:       half = 5'd0;
        4:       half = hdpr_pkg::CFG_W'($urandom_range(15, 2));
        5:       half = hdpr_pkg::CFG_W'($urandom_range(31, 17));
        6:       half = hdpr_pkg::CFG_W'($urandom_range(16, 1));
        default: half = 5'd8;
      endcase
      write_half_size(half);
      case (ph % 4)
        0: begin
          src_gap_max = 19;
          snk_gap_max = 19;
        end
        1: begin
          src_gap_max = 0;
          snk_gap_max = 0;
        end
        2: begin
          src_gap_max = 0;
          snk_gap_max = 19;
        end
        default: begin
          src_gap_max = 19;
          snk_gap_max = 0;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_pixel();
    end
  endtask

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_on <= 1'b0;
    end
  end

  initial begin
    int wait_n;
    forever begin
      wait_n = $urandom_range(snk_gap_max, 0);
      if (wait_n > 0) begin
        @(negedge clk);
        sink_wait <= 1'b1;
        repeat (wait_n - 1) @(negedge clk);
      end
      @(negedge clk);
      sink_wait <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    dot_pixel_t pix;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pix_q.size() == 0) begin
        if (n_errors < 10) $display("unexpected transaction: rgb=%06h", out_pixel_rgb);
        n_errors++;
      end else begin
        pix = pending_pix_q.pop_front();
        if (out_pixel_rgb !== pix.rgb) begin
          if (n_errors < 10) begin
            $display("mismatch: luma=%0d x=%0d y=%0d half=%0d expected=%06h actual=%06h",
                     pix.luma, pix.ofs_x, pix.ofs_y, pix.half, pix.rgb, out_pixel_rgb);
          end
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == TB_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cell_luma  = '0;
    in_offset_x   = '0;
    in_offset_y   = '0;
    cfg_valid     = 1'b0;
    cfg_half_size = '0;
    half_cur      = hdpr_pkg::CFG_W'(hdpr_pkg::HALF_RESET);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_cell();
    test_half_size_extremes();
    test_full_backpressure();
    test_random_cells();
    drain_pipe();
    if (n_errors == 0 && pending_pix_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
